// ----- hw/rtl/cna_pkg.sv -----
// Shared types and codes for the complex number ALU.
// No dependencies.
package cna_pkg;

    localparam int FIELD_BITS = 32;
    localparam int MODE_BITS  = 3;

    localparam logic [MODE_BITS-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SUB  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MUL  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DIV  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CONJ = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_MOD  = 3'd5;

    // Class tags set by the front end, used by the back end to pick a path
    typedef struct packed {
        logic div;    // divide with nonzero divisor
        logic sqrt;   // modulus
        logic dz;     // divide by zero
    } t_cls;

    localparam int CLS_BITS = $bits(t_cls);

    typedef enum logic [2:0] {
        E_IDLE,
        E_DIV_CHK,
        E_DIV_RUN,
        E_SQRT_RUN,
        E_FIN
    } t_exec_state;

endpackage

// ----- hw/rtl/cna_fifo.sv -----
// Small synchronous queue, registers only.
// Depends on nothing but its parameters.
module cna_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)))
        else $error("queue count missed a write");

    a_cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && !wr_en) |=> (r_cnt == $past(r_cnt) - (AW+1)'(1)))
        else $error("queue count missed a read");

endmodule

// ----- hw/rtl/cna_front.sv -----
// Front end: takes requests, narrows operands to the word format, tags the class.
// Depends on cna_pkg.
module cna_front import cna_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic                                   i_push,
    input  logic                                   i_q_full,
    input  logic [MODE_BITS-1:0]                   i_mode,
    input  logic signed [FIELD_BITS-1:0]           i_a_re,
    input  logic signed [FIELD_BITS-1:0]           i_a_im,
    input  logic signed [FIELD_BITS-1:0]           i_b_re,
    input  logic signed [FIELD_BITS-1:0]           i_b_im,
    output logic                                   o_q_wr,
    output logic [MODE_BITS+CLS_BITS+4*WORD_BITS-1:0] o_q_item
);
    logic signed [WORD_BITS-1:0] ar, ai, br, bi;
    logic                        b_zero;
    t_cls                        cls;

    // sign-extend or truncate to the word
    assign ar = WORD_BITS'(i_a_re);
    assign ai = WORD_BITS'(i_a_im);
    assign br = WORD_BITS'(i_b_re);
    assign bi = WORD_BITS'(i_b_im);

    assign b_zero = (br == '0) && (bi == '0);

    always_comb begin
        cls      = '0;
        cls.div  = (i_mode == MODE_DIV) && !b_zero;
        cls.dz   = (i_mode == MODE_DIV) && b_zero;
        cls.sqrt = (i_mode == MODE_MOD);
    end

    assign o_q_wr   = i_push && !i_q_full;
    assign o_q_item = {i_mode, cls, ar, ai, br, bi};

endmodule

// ----- hw/rtl/cna_back.sv -----
// Back end: product stage, ops computed directly from it, iterative divider and square root.
// Depends on cna_pkg.
module cna_back import cna_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_q_empty,
    input  logic [MODE_BITS+CLS_BITS+4*WORD_BITS-1:0] i_q_item,
    output logic                                      o_q_pop,
    input  logic                                      i_out_full,
    output logic                                      o_out_wr,
    output logic [FIELD_BITS-1:0]                     o_out_res_re,
    output logic [FIELD_BITS-1:0]                     o_out_res_im,
    output logic                                      o_out_ovf,
    output logic                                      o_out_dz
);
    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2*W;
    localparam int XW   = 2*W + 2;
    localparam int CW   = 3*W + F + 2;
    localparam int RW   = W + 4;
    localparam int CNTW = $clog2(W+1);
    localparam int IW   = MODE_BITS + CLS_BITS + 4*W;

    localparam logic signed [XW-1:0] ONE     = XW'(1);
    localparam logic signed [XW-1:0] SAT_MAX = (ONE <<< (W-1)) - ONE;
    localparam logic signed [XW-1:0] SAT_MIN = -(ONE <<< (W-1));
    localparam logic signed [XW-1:0] RND_POS = ONE <<< (F-1);
    localparam logic signed [XW-1:0] RND_NEG = RND_POS - ONE;

    function automatic logic [W:0] f_sat(input logic signed [XW-1:0] x);
        logic [W:0] r;
        if (x > SAT_MAX) begin
            r = {1'b1, SAT_MAX[W-1:0]};
        end else if (x < SAT_MIN) begin
            r = {1'b1, SAT_MIN[W-1:0]};
        end else begin
            r = {1'b0, x[W-1:0]};
        end
        return r;
    endfunction

    // drop the fraction, nearest, ties away from zero
    function automatic logic signed [XW-1:0] f_rnd(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        t = x + (x[XW-1] ? RND_NEG : RND_POS);
        return t >>> F;
    endfunction

    // queue item
    logic [MODE_BITS-1:0]  q_mode;
    t_cls                  q_cls;
    logic signed [W-1:0]   q_ar, q_ai, q_br, q_bi, q_u0, q_u1;

    assign q_mode = i_q_item[IW-1 -: MODE_BITS];
    assign q_cls  = t_cls'(i_q_item[IW-MODE_BITS-1 -: CLS_BITS]);
    assign q_ar   = i_q_item[4*W-1 -: W];
    assign q_ai   = i_q_item[3*W-1 -: W];
    assign q_br   = i_q_item[2*W-1 -: W];
    assign q_bi   = i_q_item[W-1 -: W];
    assign q_u0   = q_cls.sqrt ? q_ar : q_br;
    assign q_u1   = q_cls.sqrt ? q_ai : q_bi;

    // product stage
    logic                  r_p_vld;
    logic [MODE_BITS-1:0]  r_p_mode;
    t_cls                  r_p_cls;
    logic signed [W-1:0]   r_p_ar, r_p_ai, r_p_br, r_p_bi;
    logic signed [PW-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic                  p_take;
    logic                  e_take;

    assign p_take  = !r_p_vld || e_take;
    assign o_q_pop = p_take && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (p_take) begin
            r_p_vld <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_p_mode <= q_mode;
            r_p_cls  <= q_cls;
            r_p_ar   <= q_ar;
            r_p_ai   <= q_ai;
            r_p_br   <= q_br;
            r_p_bi   <= q_bi;
            r_p0     <= q_ar * q_br;
            r_p1     <= q_ai * q_bi;
            r_p2     <= q_ar * q_bi;
            r_p3     <= q_ai * q_br;
            r_p4     <= q_u0 * q_u0;
            r_p5     <= q_u1 * q_u1;
        end
    end

    // iterative units
    t_exec_state           r_state, n_state;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_u_div;
    logic [CW-1:0]         r_rem [2];
    logic [CW-1:0]         r_d;
    logic [CW-1:0]         r_den;
    logic [W+1:0]          r_q [2];
    logic                  r_neg [2];
    logic                  r_big [2];
    logic [PW-1:0]         r_s;
    logic [RW-1:0]         r_srem;
    logic [W:0]            r_root;
    logic                  ld_div, ld_sqrt, sel_fin;

    logic signed [XW-1:0]  num [2];
    logic [XW-1:0]         num_mag [2];
    logic [CW-1:0]         den;
    logic [RW-1:0]         sq_cur, sq_trial;

    assign num[0] = XW'(r_p0) + XW'(r_p1);
    assign num[1] = XW'(r_p3) - XW'(r_p2);
    assign den    = CW'(r_p4) + CW'(r_p5);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            num_mag[l] = num[l][XW-1] ? XW'(-num[l]) : XW'(num[l]);
        end
    end

    assign sq_cur   = {r_srem[RW-3:0], r_s[PW-1 -: 2]};
    assign sq_trial = (RW'(r_root) << 2) | RW'(1);

    // final values of the iterative paths
    logic signed [XW-1:0]  f_val [2];
    logic [W+1:0]          f_q [2];
    logic [W:0]            f_sat_v [2];
    logic [W:0]            f_root;
    logic [W:0]            f_sat_root;
    logic [W-1:0]          fin_re, fin_im;
    logic                  fin_ovf;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            f_q[l]   = r_q[l] + (W+2)'(((r_rem[l] << 1) >= r_den) ? 1 : 0);
            f_val[l] = r_neg[l] ? -XW'(f_q[l]) : XW'(f_q[l]);
            if (r_big[l]) begin
                f_sat_v[l] = r_neg[l] ? {1'b1, SAT_MIN[W-1:0]} : {1'b1, SAT_MAX[W-1:0]};
            end else begin
                f_sat_v[l] = f_sat(f_val[l]);
            end
        end
        f_root     = r_root + (W+1)'((RW'(r_srem) > RW'(r_root)) ? 1 : 0);
        f_sat_root = f_sat(XW'(f_root));
        if (r_u_div) begin
            fin_re  = f_sat_v[0][W-1:0];
            fin_im  = f_sat_v[1][W-1:0];
            fin_ovf = f_sat_v[0][W] || f_sat_v[1][W];
        end else begin
            fin_re  = f_sat_root[W-1:0];
            fin_im  = '0;
            fin_ovf = f_sat_root[W];
        end
    end

    always_comb begin
        n_state  = r_state;
        e_take   = 1'b0;
        o_out_wr = 1'b0;
        ld_div   = 1'b0;
        ld_sqrt  = 1'b0;
        sel_fin  = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (r_p_vld) begin
                    if (r_p_cls.div) begin
                        e_take  = 1'b1;
                        ld_div  = 1'b1;
                        n_state = E_DIV_CHK;
                    end else if (r_p_cls.sqrt) begin
                        e_take  = 1'b1;
                        ld_sqrt = 1'b1;
                        n_state = E_SQRT_RUN;
                    end else if (!i_out_full) begin
                        e_take   = 1'b1;
                        o_out_wr = 1'b1;
                    end
                end
            end
            E_DIV_CHK: begin
                n_state = E_DIV_RUN;
            end
            E_DIV_RUN: begin
                if (r_cnt == '0) begin
                    n_state = E_FIN;
                end
            end
            E_SQRT_RUN: begin
                if (r_cnt == '0) begin
                    n_state = E_FIN;
                end
            end
            E_FIN: begin
                sel_fin = 1'b1;
                if (!i_out_full) begin
                    o_out_wr = 1'b1;
                    n_state  = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == E_DIV_CHK) begin
                r_cnt <= CNTW'(W);
            end else if (ld_sqrt) begin
                r_cnt <= CNTW'(W-1);
            end else if ((r_state == E_DIV_RUN || r_state == E_SQRT_RUN) && r_cnt != '0) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_div) begin
            r_u_div <= 1'b1;
            r_den   <= den;
            r_d     <= den << W;
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= CW'(num_mag[l]) << F;
                r_neg[l] <= num[l][XW-1];
                r_q[l]   <= '0;
            end
        end else if (r_state == E_DIV_CHK) begin
            for (int l = 0; l < 2; l++) begin
                r_big[l] <= (r_rem[l] >= (r_d << 1));
            end
        end else if (r_state == E_DIV_RUN) begin
            for (int l = 0; l < 2; l++) begin
                if (r_rem[l] >= r_d) begin
                    r_rem[l] <= r_rem[l] - r_d;
                    r_q[l]   <= {r_q[l][W:0], 1'b1};
                end else begin
                    r_q[l]   <= {r_q[l][W:0], 1'b0};
                end
            end
            r_d <= r_d >> 1;
        end
        if (ld_sqrt) begin
            r_u_div <= 1'b0;
            r_s     <= PW'(r_p4) + PW'(r_p5);
            r_srem  <= '0;
            r_root  <= '0;
        end else if (r_state == E_SQRT_RUN) begin
            r_s <= r_s << 2;
            if (sq_cur >= sq_trial) begin
                r_srem <= sq_cur - sq_trial;
                r_root <= {r_root[W-1:0], 1'b1};
            end else begin
                r_srem <= sq_cur;
                r_root <= {r_root[W-1:0], 1'b0};
            end
        end
    end

    // results computed directly from the product stage
    logic signed [XW-1:0] c_re, c_im;
    logic [W:0]           c_sat_re, c_sat_im;
    logic signed [W-1:0]  out_re_w, out_im_w;

    always_comb begin
        c_re = '0;
        c_im = '0;
        case (r_p_mode)
            MODE_ADD: begin
                c_re = XW'(r_p_ar) + XW'(r_p_br);
                c_im = XW'(r_p_ai) + XW'(r_p_bi);
            end
            MODE_SUB: begin
                c_re = XW'(r_p_ar) - XW'(r_p_br);
                c_im = XW'(r_p_ai) - XW'(r_p_bi);
            end
            MODE_MUL: begin
                c_re = f_rnd(XW'(r_p0) - XW'(r_p1));
                c_im = f_rnd(XW'(r_p2) + XW'(r_p3));
            end
            MODE_CONJ: begin
                c_re = XW'(r_p_ar);
                c_im = -XW'(r_p_ai);
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
    end

    assign c_sat_re = f_sat(c_re);
    assign c_sat_im = f_sat(c_im);

    assign out_re_w = sel_fin ? fin_re : c_sat_re[W-1:0];
    assign out_im_w = sel_fin ? fin_im : c_sat_im[W-1:0];

    assign o_out_res_re = FIELD_BITS'(out_re_w);
    assign o_out_res_im = FIELD_BITS'(out_im_w);
    assign o_out_ovf    = sel_fin ? fin_ovf : (c_sat_re[W] || c_sat_im[W]);
    assign o_out_dz     = !sel_fin && r_p_cls.dz;

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != E_IDLE) |-> !e_take)
        else $error("product stage consumed while a unit is busy");

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_wr && o_out_dz) |-> (!o_out_ovf && o_out_res_re == '0 && o_out_res_im == '0))
        else $error("divide by zero result not clean");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_DIV_RUN) |-> (r_cnt <= CNTW'(W)))
        else $error("divider step count out of range");

endmodule

// ----- hw/rtl/complex_number_alu_core.sv -----
// Complex number ALU, signed fixed point; top level.
// Usage:
//   Requests enter through a queue-style port: an item is taken at a clock edge
//   with push high and full low. Results leave the same way: the oldest result
//   sits on o_res_re/o_res_im/o_overflow/o_divide_by_zero while empty is low and
//   is taken at an edge with pop high.
//   Modes: add, sub, mul, div, conjugate of a, modulus of a. Results are rounded
//   to nearest (ties away from zero) and saturated; saturation sets o_overflow.
//   Divide by a zero divisor gives zero and sets o_divide_by_zero.
// Timing:
//   Add, sub, mul, conjugate and unused modes: one item per cycle while the
//   execution unit is idle and the result queue is not full; the result passes
//   through the input queue, the product stage and the result queue. Divide
//   holds the execution unit while it makes one quotient bit per cycle for both
//   parts at once; modulus holds it while it makes one root bit per cycle. Items
//   behind them wait in the product stage and the input queue; order is kept.
// Reset: synchronous, active low; both queues empty, execution unit idle.
// Stall: when pop stays low, the result queue fills, execution stops and the
//   input queue fills until full rises; nothing is dropped.
module complex_number_alu_core import cna_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [MODE_BITS-1:0]         i_mode,
    input  logic signed [FIELD_BITS-1:0] i_a_re,
    input  logic signed [FIELD_BITS-1:0] i_a_im,
    input  logic signed [FIELD_BITS-1:0] i_b_re,
    input  logic signed [FIELD_BITS-1:0] i_b_im,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [FIELD_BITS-1:0] o_res_re,
    output logic signed [FIELD_BITS-1:0] o_res_im,
    output logic                         o_overflow,
    output logic                         o_divide_by_zero
);
    localparam int IW = MODE_BITS + CLS_BITS + 4*WORD_BITS;
    localparam int OW = 2*FIELD_BITS + 2;

    logic          q_wr, q_full, q_empty, q_pop;
    logic [IW-1:0] q_wdata, q_rdata;
    logic          out_wr, out_full, out_ovf, out_dz;
    logic [FIELD_BITS-1:0] out_re, out_im;
    logic [OW-1:0] out_rdata;

    cna_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_push   (push),
        .i_q_full (q_full),
        .i_mode   (i_mode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_q_wr   (q_wr),
        .o_q_item (q_wdata)
    );

    cna_fifo #(.WIDTH(IW), .DEPTH(4)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cna_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_item     (q_rdata),
        .o_q_pop      (q_pop),
        .i_out_full   (out_full),
        .o_out_wr     (out_wr),
        .o_out_res_re (out_re),
        .o_out_res_im (out_im),
        .o_out_ovf    (out_ovf),
        .o_out_dz     (out_dz)
    );

    cna_fifo #(.WIDTH(OW), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata ({out_re, out_im, out_ovf, out_dz}),
        .i_rd    (pop),
        .o_rdata (out_rdata),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign full             = q_full;
    assign o_res_re         = out_rdata[OW-1 -: FIELD_BITS];
    assign o_res_im         = out_rdata[FIELD_BITS+1 -: FIELD_BITS];
    assign o_overflow       = out_rdata[1];
    assign o_divide_by_zero = out_rdata[0];

endmodule
